// File: rtl/usb_ais_pkg.sv
// ----------------------------------------------------------------------------
// usb_ais_pkg
// Shared types and constants of the USB attach identity sequencer: event
// codes, identity and phase codes, register indexes and item layouts.
// ----------------------------------------------------------------------------
`default_nettype none

package usb_ais_pkg;

  // Event codes carried in the action field
  typedef enum logic [2:0] {
    ACT_POLL       = 3'd0,
    ACT_START      = 3'd1,
    ACT_WANT_FULL  = 3'd2,
    ACT_WANT_IDLE  = 3'd3,
    ACT_WANT_DET   = 3'd4,
    ACT_RECONNECT  = 3'd5,
    ACT_DESC_SERVED = 3'd6
  } action_e;

  // Wanted bus identity
  typedef enum logic [1:0] {
    ID_DETACHED = 2'd0,
    ID_IDLE     = 2'd1,
    ID_FULL     = 2'd2
  } ident_e;

  // Attach phase
  typedef enum logic [1:0] {
    PH_DETACHED   = 2'd0,
    PH_WAITING    = 2'd1,
    PH_CONNECTING = 2'd2,
    PH_SERVED     = 2'd3
  } phase_e;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_WAKE_EN  = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_IDLE_EN  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_REENUM   = 2'd2;

  localparam int unsigned DelayW   = 24;
  localparam int unsigned TimeW    = 64;
  localparam logic [DelayW-1:0] REENUM_RESET = 24'd250000;

  typedef struct packed {
    logic              wake_enabled;
    logic              idle_identity_enabled;
    logic [DelayW-1:0] reenumerate_delay;
  } cfg_t;

  typedef struct packed {
    logic [2:0]       action;
    logic [TimeW-1:0] time_now;
    logic             bus_suspended;
    logic             keyboard_busy;
    logic             link_connected;
    logic             served_was_idle;
  } evt_t;

  typedef struct packed {
    logic       connect_pulse;
    logic       disconnect_pulse;
    logic       reconnect_note;
    logic       idle_descriptor_wanted;
    logic       idle_identity_active;
    logic       gamepad_ready;
    logic [1:0] attach_phase;
  } res_t;

endpackage

`default_nettype wire

// File: rtl/usb_ais_if.sv
// ----------------------------------------------------------------------------
// usb_ais_if
// Valid/ready channels of the sequencer: event items in, result items out,
// and the configuration write channel.
// ----------------------------------------------------------------------------
`default_nettype none

interface usb_ais_evt_if;
  logic        valid;
  logic        ready;
  logic [2:0]  action;
  logic [63:0] time_now;
  logic        bus_suspended;
  logic        keyboard_busy;
  logic        link_connected;
  logic        served_was_idle;

  modport source (output valid, action, time_now, bus_suspended, keyboard_busy,
                  link_connected, served_was_idle, input ready);
  modport sink   (input valid, action, time_now, bus_suspended, keyboard_busy,
                  link_connected, served_was_idle, output ready);
endinterface

interface usb_ais_res_if;
  logic       valid;
  logic       ready;
  logic       connect_pulse;
  logic       disconnect_pulse;
  logic       reconnect_note;
  logic       idle_descriptor_wanted;
  logic       idle_identity_active;
  logic       gamepad_ready;
  logic [1:0] attach_phase;

  modport source (output valid, connect_pulse, disconnect_pulse, reconnect_note,
                  idle_descriptor_wanted, idle_identity_active, gamepad_ready,
                  attach_phase, input ready);
  modport sink   (input valid, connect_pulse, disconnect_pulse, reconnect_note,
                  idle_descriptor_wanted, idle_identity_active, gamepad_ready,
                  attach_phase, output ready);
endinterface

interface usb_ais_cfg_if;
  logic        valid;
  logic        ready;
  logic [1:0]  index;
  logic [23:0] data;

  modport source (output valid, index, data, input ready);
  modport sink   (input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: rtl/usb_ais_cfg.sv
// ----------------------------------------------------------------------------
// usb_ais_cfg
// Configuration register file: wake enable, idle identity enable and the
// re-enumerate delay. Writes are taken in every cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_ais_cfg (
  input  wire logic           clk_i,
  input  wire logic           rst_ni,
  usb_ais_cfg_if.sink         cfg_i,
  output usb_ais_pkg::cfg_t   cfg_o
);

  usb_ais_pkg::cfg_t cfg_q, cfg_d;

  assign cfg_i.ready = 1'b1;

  // Decode the write index; indexes past the list are dropped
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_i.valid) begin
      unique case (cfg_i.index)
        usb_ais_pkg::CFG_WAKE_EN: cfg_d.wake_enabled          = cfg_i.data[0];
        usb_ais_pkg::CFG_IDLE_EN: cfg_d.idle_identity_enabled = cfg_i.data[0];
        usb_ais_pkg::CFG_REENUM:  cfg_d.reenumerate_delay     = cfg_i.data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.wake_enabled          <= 1'b0;
      cfg_q.idle_identity_enabled <= 1'b0;
      cfg_q.reenumerate_delay     <= usb_ais_pkg::REENUM_RESET;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

`default_nettype wire

// File: rtl/usb_ais_seq.sv
// ----------------------------------------------------------------------------
// usb_ais_seq
// Attach sequencing state and the single-pass event logic. On fire_i the
// registered event is applied to the state and the result item is formed
// from the updated state.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_ais_seq (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          fire_i,
  input  usb_ais_pkg::evt_t  evt_i,
  input  usb_ais_pkg::cfg_t  cfg_i,
  output usb_ais_pkg::res_t  res_o
);

  usb_ais_pkg::ident_e wanted_q, wanted_d;
  usb_ais_pkg::phase_e phase_q, phase_d;
  logic idle_desc_q, idle_desc_d;
  logic served_idle_q, served_idle_d;
  logic rc_pend_q, rc_pend_d;
  logic [usb_ais_pkg::TimeW-1:0] detach_time_q, detach_time_d;

  logic pls_connect, pls_disconnect, pls_note;
  logic idle_target;
  logic delay_met;
  logic [usb_ais_pkg::TimeW-1:0] elapsed;

  // Elapsed time since detach, wrapping, unsigned compare against the delay
  assign elapsed   = evt_i.time_now - detach_time_q;
  assign delay_met = elapsed >= {{(usb_ais_pkg::TimeW-usb_ais_pkg::DelayW){1'b0}},
                                 cfg_i.reenumerate_delay};
  assign idle_target = (wanted_q == usb_ais_pkg::ID_IDLE);

  // Event decode and state update
  always_comb begin
    wanted_d       = wanted_q;
    phase_d        = phase_q;
    idle_desc_d    = idle_desc_q;
    served_idle_d  = served_idle_q;
    rc_pend_d      = rc_pend_q;
    detach_time_d  = detach_time_q;
    pls_connect    = 1'b0;
    pls_disconnect = 1'b0;
    pls_note       = 1'b0;
    if (fire_i) begin
      unique case (usb_ais_pkg::action_e'(evt_i.action))
        usb_ais_pkg::ACT_POLL: begin
          if (!evt_i.bus_suspended && !evt_i.keyboard_busy) begin
            priority if (rc_pend_q) begin
              // pending reconnect: drop off the bus and start over
              rc_pend_d = 1'b0;
              pls_note  = 1'b1;
              pls_disconnect = (phase_q != usb_ais_pkg::PH_DETACHED);
              if (wanted_q == usb_ais_pkg::ID_DETACHED) begin
                phase_d = usb_ais_pkg::PH_DETACHED;
              end else begin
                idle_desc_d   = idle_target;
                served_idle_d = 1'b0;
                phase_d       = usb_ais_pkg::PH_WAITING;
                detach_time_d = evt_i.time_now;
              end
            end else if (wanted_q == usb_ais_pkg::ID_DETACHED) begin
              if (phase_q != usb_ais_pkg::PH_DETACHED) begin
                pls_note       = 1'b1;
                pls_disconnect = 1'b1;
                phase_d        = usb_ais_pkg::PH_DETACHED;
                detach_time_d  = evt_i.time_now;
              end
            end else if (phase_q == usb_ais_pkg::PH_SERVED &&
                         served_idle_q == idle_target) begin
              // already serving the wanted identity
            end else if (phase_q == usb_ais_pkg::PH_SERVED ||
                         (phase_q == usb_ais_pkg::PH_CONNECTING &&
                          idle_desc_q != idle_target)) begin
              // identity change: detach and wait out the delay
              pls_note       = 1'b1;
              pls_disconnect = 1'b1;
              phase_d        = usb_ais_pkg::PH_WAITING;
              idle_desc_d    = idle_target;
              detach_time_d  = evt_i.time_now;
            end else if (phase_q == usb_ais_pkg::PH_DETACHED) begin
              phase_d       = usb_ais_pkg::PH_WAITING;
              idle_desc_d   = idle_target;
              detach_time_d = evt_i.time_now;
            end else if (phase_q == usb_ais_pkg::PH_WAITING) begin
              idle_desc_d = idle_target;
              if (delay_met) begin
                phase_d     = usb_ais_pkg::PH_CONNECTING;
                pls_connect = 1'b1;
              end
            end else begin
              // connecting with the right descriptor: nothing to do
            end
          end
        end
        usb_ais_pkg::ACT_START: begin
          if (!cfg_i.wake_enabled) begin
            wanted_d    = usb_ais_pkg::ID_DETACHED;
            phase_d     = usb_ais_pkg::PH_DETACHED;
            idle_desc_d = 1'b0;
          end else if (cfg_i.idle_identity_enabled) begin
            wanted_d    = usb_ais_pkg::ID_IDLE;
            phase_d     = usb_ais_pkg::PH_WAITING;
            idle_desc_d = 1'b1;
          end else begin
            wanted_d    = usb_ais_pkg::ID_FULL;
            phase_d     = usb_ais_pkg::PH_WAITING;
            idle_desc_d = 1'b0;
          end
          served_idle_d = 1'b0;
          detach_time_d = evt_i.time_now;
        end
        usb_ais_pkg::ACT_WANT_FULL: wanted_d = usb_ais_pkg::ID_FULL;
        usb_ais_pkg::ACT_WANT_IDLE: wanted_d = usb_ais_pkg::ID_IDLE;
        usb_ais_pkg::ACT_WANT_DET:  wanted_d = usb_ais_pkg::ID_DETACHED;
        usb_ais_pkg::ACT_RECONNECT: begin
          if (!cfg_i.wake_enabled) begin
            wanted_d = usb_ais_pkg::ID_DETACHED;
          end else if (!evt_i.link_connected && cfg_i.idle_identity_enabled) begin
            wanted_d = usb_ais_pkg::ID_IDLE;
          end else begin
            wanted_d = usb_ais_pkg::ID_FULL;
          end
          rc_pend_d = 1'b1;
        end
        usb_ais_pkg::ACT_DESC_SERVED: begin
          served_idle_d = evt_i.served_was_idle;
          phase_d       = usb_ais_pkg::PH_SERVED;
        end
        default: ;  // unused code: no change
      endcase
    end
  end

  // Result item from the post-event state
  always_comb begin
    res_o.connect_pulse          = pls_connect;
    res_o.disconnect_pulse       = pls_disconnect;
    res_o.reconnect_note         = pls_note;
    res_o.idle_descriptor_wanted = idle_desc_d;
    res_o.idle_identity_active   = (phase_d == usb_ais_pkg::PH_SERVED) && served_idle_d;
    res_o.gamepad_ready          = (phase_d == usb_ais_pkg::PH_SERVED) && !served_idle_d;
    res_o.attach_phase           = phase_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wanted_q      <= usb_ais_pkg::ID_DETACHED;
      phase_q       <= usb_ais_pkg::PH_DETACHED;
      idle_desc_q   <= 1'b0;
      served_idle_q <= 1'b0;
      rc_pend_q     <= 1'b0;
      detach_time_q <= '0;
    end else begin
      wanted_q      <= wanted_d;
      phase_q       <= phase_d;
      idle_desc_q   <= idle_desc_d;
      served_idle_q <= served_idle_d;
      rc_pend_q     <= rc_pend_d;
      detach_time_q <= detach_time_d;
    end
  end

endmodule

`default_nettype wire

// File: rtl/usb_attach_identity_sequencer.sv
// ----------------------------------------------------------------------------
// usb_attach_identity_sequencer
// Moves a USB device's bus attachment between detached, idle and full
// identities and times the re-enumerate delay.
//
// Channels: evt_i takes event items (poll, start, identity requests,
// reconnect, descriptor served); res_o returns one result item per event
// with the connect/disconnect/reconnect-note pulses and the status after
// the event. cfg_i writes the three configuration registers; it is always
// ready. The user must write it only while no event is in flight; the block
// does not enforce this. An accepted event is applied as it moves from the
// input register to the output register, raising res_o.valid. Throughput
// is one event per cycle while the receiver does not stall; the path is
// the input register, one 64-bit subtract-compare and the output register.
// When the receiver stalls, the result holds in the output register, one
// more event waits in the input register, and evt_i.ready then drops.
// Reset clears both valid flags, the sequencing state (detached, no pending
// reconnect, detach time zero) and sets the delay to 250000 us.
// ----------------------------------------------------------------------------
`default_nettype none

module usb_attach_identity_sequencer (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  usb_ais_evt_if.sink  evt_i,
  usb_ais_res_if.source res_o,
  usb_ais_cfg_if.sink  cfg_i
);

  usb_ais_pkg::cfg_t cfg;
  usb_ais_pkg::evt_t evt_q;
  usb_ais_pkg::res_t res_d, res_q;
  logic in_valid_q;
  logic out_valid_q;
  logic advance;

  usb_ais_cfg u_cfg (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cfg_i  (cfg_i),
    .cfg_o  (cfg)
  );

  // Event moves from the input register to the output register
  assign advance     = in_valid_q && (!out_valid_q || res_o.ready);
  assign evt_i.ready = !in_valid_q || advance;

  usb_ais_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .evt_i  (evt_q),
    .cfg_i  (cfg),
    .res_o  (res_d)
  );

  // Valid flags
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (evt_i.ready) begin
        in_valid_q <= evt_i.valid;
      end
      if (advance) begin
        out_valid_q <= 1'b1;
      end else if (res_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    if (evt_i.valid && evt_i.ready) begin
      evt_q.action          <= evt_i.action;
      evt_q.time_now        <= evt_i.time_now;
      evt_q.bus_suspended   <= evt_i.bus_suspended;
      evt_q.keyboard_busy   <= evt_i.keyboard_busy;
      evt_q.link_connected  <= evt_i.link_connected;
      evt_q.served_was_idle <= evt_i.served_was_idle;
    end
    if (advance) begin
      res_q <= res_d;
    end
  end

  assign res_o.valid                  = out_valid_q;
  assign res_o.connect_pulse          = res_q.connect_pulse;
  assign res_o.disconnect_pulse       = res_q.disconnect_pulse;
  assign res_o.reconnect_note         = res_q.reconnect_note;
  assign res_o.idle_descriptor_wanted = res_q.idle_descriptor_wanted;
  assign res_o.idle_identity_active   = res_q.idle_identity_active;
  assign res_o.gamepad_ready          = res_q.gamepad_ready;
  assign res_o.attach_phase           = res_q.attach_phase;

endmodule

`default_nettype wire

// File: test/testbench.sv
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for usb_attach_identity_sequencer. A walked table of
// directed events and register writes comes first, then random events in
// several register settings. Every accepted event is run through a local
// model of the attach sequence, and each result item is compared field by
// field with the oldest prediction. The sender works in bursts and the
// receiver stalls on its own pattern.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  import usb_ais_pkg::*;

  // Action code with no meaning; the block must leave everything alone
  localparam logic [2:0] ACT_UNUSED = 3'd7;

  // Event flag bits for the directed table: {suspended, kbd busy, link, idle served}
  localparam logic [3:0] F_NONE  = 4'b0000;
  localparam logic [3:0] F_SUSP  = 4'b1000;
  localparam logic [3:0] F_KBD   = 4'b0100;
  localparam logic [3:0] F_LINK  = 4'b0010;
  localparam logic [3:0] F_WIDLE = 4'b0001;
  localparam logic [3:0] F_ALL   = 4'b1111;

  localparam res_t QUIET = '0;  // no pulses, detached, nothing served

  localparam int unsigned RandPhases    = 8;
  localparam int unsigned ItemsPerPhase = 240;

  // One row of the directed table: a register write or an event
  typedef struct packed {
    logic               is_cfg;
    logic [CfgIdxW-1:0] idx;
    logic [DelayW-1:0]  data;
    evt_t               ev;
    logic               typed;
    res_t               res;
  } step_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic sink_ready = 1'b0;

  usb_ais_evt_if evt_if ();
  usb_ais_res_if res_if ();
  usb_ais_cfg_if cfg_if ();

  assign res_if.ready = sink_ready;

  usb_attach_identity_sequencer dut (
    .clk_i (clk),
    .rst_ni(rst_n),
    .evt_i (evt_if),
    .res_o (res_if),
    .cfg_i (cfg_if)
  );

  // Clock, 10 ns period
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Register shadows
  logic              cfg_wake;
  logic              cfg_idle;
  logic [DelayW-1:0] cfg_delay;

  // Attach sequence state of the local model
  ident_e            wanted_now;
  phase_e            phase_now;
  logic              idle_desc;
  logic              served_idle_q;
  logic              reconnect_due;
  logic [TimeW-1:0]  detach_us;

  res_t        attach_results_due[$];
  step_t       dir_steps[$];
  int unsigned err_count = 0;
  int unsigned burst_left = 0;
  logic [TimeW-1:0] clock_us;

  // Model of one event: updates the state, returns the result item
  function automatic res_t predict_attach(input evt_t ev);
    res_t r;
    logic idle_target;
    r = '0;
    case (ev.action)
      ACT_POLL: begin
        if (!ev.bus_suspended && !ev.keyboard_busy) begin
          idle_target = (wanted_now == ID_IDLE);
          if (reconnect_due) begin
            // carry out the marked reconnect
            reconnect_due = 1'b0;
            r.reconnect_note = 1'b1;
            if (phase_now != PH_DETACHED) r.disconnect_pulse = 1'b1;
            if (wanted_now == ID_DETACHED) begin
              phase_now = PH_DETACHED;
            end else begin
              idle_desc = idle_target;
              served_idle_q = 1'b0;
              phase_now = PH_WAITING;
              detach_us = ev.time_now;
            end
          end else if (wanted_now == ID_DETACHED) begin
            if (phase_now != PH_DETACHED) begin
              r.reconnect_note = 1'b1;
              r.disconnect_pulse = 1'b1;
              phase_now = PH_DETACHED;
              detach_us = ev.time_now;
            end
          end else if (phase_now == PH_SERVED && served_idle_q == idle_target) begin
            // already served with the wanted identity
          end else if (phase_now == PH_SERVED ||
                       (phase_now == PH_CONNECTING && idle_desc != idle_target)) begin
            r.reconnect_note = 1'b1;
            r.disconnect_pulse = 1'b1;
            phase_now = PH_WAITING;
            idle_desc = idle_target;
            detach_us = ev.time_now;
          end else if (phase_now == PH_DETACHED) begin
            phase_now = PH_WAITING;
            idle_desc = idle_target;
            detach_us = ev.time_now;
          end else if (phase_now == PH_WAITING) begin
            // unsigned elapsed time, wraps modulo 2^64
            idle_desc = idle_target;
            if (ev.time_now - detach_us >= {40'd0, cfg_delay}) begin
              phase_now = PH_CONNECTING;
              r.connect_pulse = 1'b1;
            end
          end
        end
      end
      ACT_START: begin
        if (!cfg_wake) wanted_now = ID_DETACHED;
        else if (cfg_idle) wanted_now = ID_IDLE;
        else wanted_now = ID_FULL;
        if (wanted_now == ID_DETACHED) phase_now = PH_DETACHED;
        else phase_now = PH_WAITING;
        idle_desc = (wanted_now == ID_IDLE);
        served_idle_q = 1'b0;
        detach_us = ev.time_now;
      end
      ACT_WANT_FULL: wanted_now = ID_FULL;
      ACT_WANT_IDLE: wanted_now = ID_IDLE;
      ACT_WANT_DET:  wanted_now = ID_DETACHED;
      ACT_RECONNECT: begin
        if (!cfg_wake) wanted_now = ID_DETACHED;
        else if (!ev.link_connected && cfg_idle) wanted_now = ID_IDLE;
        else wanted_now = ID_FULL;
        reconnect_due = 1'b1;
      end
      ACT_DESC_SERVED: begin
        served_idle_q = ev.served_was_idle;
        phase_now = PH_SERVED;
      end
      default: ;
    endcase
    r.idle_descriptor_wanted = idle_desc;
    r.idle_identity_active = (phase_now == PH_SERVED) && served_idle_q;
    r.gamepad_ready = (phase_now == PH_SERVED) && !served_idle_q;
    r.attach_phase = phase_now;
    return r;
  endfunction

  // Table row builders
  function automatic step_t evt_row(input logic [2:0] act, input logic [TimeW-1:0] t_us,
                                    input logic [3:0] flags);
    step_t s;
    s = '0;
    s.ev.action = act;
    s.ev.time_now = t_us;
    {s.ev.bus_suspended, s.ev.keyboard_busy, s.ev.link_connected,
     s.ev.served_was_idle} = flags;
    return s;
  endfunction

  function automatic step_t chk_row(input logic [2:0] act, input logic [TimeW-1:0] t_us,
                                    input logic [3:0] flags, input res_t want);
    step_t s;
    s = evt_row(act, t_us, flags);
    s.typed = 1'b1;
    s.res = want;
    return s;
  endfunction

  function automatic step_t cfg_row(input logic [CfgIdxW-1:0] idx,
                                    input logic [DelayW-1:0] val);
    step_t s;
    s = '0;
    s.is_cfg = 1'b1;
    s.idx = idx;
    s.data = val;
    return s;
  endfunction

  // Random event; time mostly moves forward, sometimes lands on the delay edge
  function automatic evt_t random_event();
    evt_t ev;
    int unsigned pick;
    ev = '0;
    pick = $urandom_range(0, 99);
    if (pick < 45) ev.action = ACT_POLL;
    else if (pick < 52) ev.action = ACT_START;
    else if (pick < 60) ev.action = ACT_WANT_FULL;
    else if (pick < 68) ev.action = ACT_WANT_IDLE;
    else if (pick < 74) ev.action = ACT_WANT_DET;
    else if (pick < 83) ev.action = ACT_RECONNECT;
    else if (pick < 97) ev.action = ACT_DESC_SERVED;
    else ev.action = ACT_UNUSED;
    pick = $urandom_range(0, 9);
    if (pick < 6) begin
      clock_us = clock_us + $urandom_range(0, cfg_delay / 4 + 3);
      ev.time_now = clock_us;
    end else if (pick < 8) begin
      ev.time_now = detach_us + 64'(cfg_delay) + 64'($urandom_range(0, 2)) - 64'd1;
      clock_us = ev.time_now;
    end else if (pick < 9) begin
      ev.time_now = {$urandom, $urandom};
    end else begin
      ev.time_now = clock_us - 64'($urandom_range(1, 50));
    end
    ev.bus_suspended = ($urandom_range(0, 9) == 0);
    ev.keyboard_busy = ($urandom_range(0, 9) == 0);
    ev.link_connected = 1'($urandom_range(0, 1));
    ev.served_was_idle = 1'($urandom_range(0, 1));
    return ev;
  endfunction

  // Offer one event; on acceptance queue what it must produce
  task automatic send_evt(input evt_t ev, input logic typed, input res_t want);
    res_t r;
    evt_if.valid <= 1'b1;
    evt_if.action <= ev.action;
    evt_if.time_now <= ev.time_now;
    evt_if.bus_suspended <= ev.bus_suspended;
    evt_if.keyboard_busy <= ev.keyboard_busy;
    evt_if.link_connected <= ev.link_connected;
    evt_if.served_was_idle <= ev.served_was_idle;
    do @(posedge clk); while (!evt_if.ready);
    r = predict_attach(ev);
    attach_results_due.push_back(typed ? want : r);
  endtask

  // Burst pacing: at the end of a burst drop valid for a random gap
  task automatic pace_sender();
    int unsigned gap;
    if (burst_left > 0) burst_left--;
    if (burst_left == 0) begin
      burst_left = ($urandom_range(0, 3) == 0) ? $urandom_range(20, 60)
                                               : $urandom_range(1, 8);
      gap = $urandom_range(1, 6);
      evt_if.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Idle the sender until every result is back
  task automatic drain_results();
    evt_if.valid <= 1'b0;
    do @(posedge clk); while (attach_results_due.size() != 0);
  endtask

  // Register write, only with nothing in flight
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [DelayW-1:0] val);
    drain_results();
    repeat (4) @(posedge clk);
    cfg_if.valid <= 1'b1;
    cfg_if.index <= idx;
    cfg_if.data <= val;
    do @(posedge clk); while (!cfg_if.ready);
    cfg_if.valid <= 1'b0;
    case (idx)
      CFG_WAKE_EN: cfg_wake = val[0];
      CFG_IDLE_EN: cfg_idle = val[0];
      CFG_REENUM:  cfg_delay = val;
      default: ;
    endcase
  endtask

  // Receiver: ready pattern, in one of four modes picked at random
  int unsigned sink_cyc = 0;
  int unsigned sink_mode = 0;
  always @(posedge clk) begin
    sink_cyc <= sink_cyc + 1;
    if (sink_cyc % 64 == 0) sink_mode <= $urandom_range(0, 3);
    case (sink_mode)
      0: sink_ready <= 1'b1;
      1: sink_ready <= 1'($urandom_range(0, 1));
      2: sink_ready <= ($urandom_range(0, 3) == 0);
      default: sink_ready <= sink_cyc[1] ^ sink_cyc[3];
    endcase
  end

  // Result checker
  always @(posedge clk) begin : result_check
    res_t got, want;
    if (rst_n && res_if.valid && res_if.ready) begin
      got = {res_if.connect_pulse, res_if.disconnect_pulse, res_if.reconnect_note,
             res_if.idle_descriptor_wanted, res_if.idle_identity_active,
             res_if.gamepad_ready, res_if.attach_phase};
      if (attach_results_due.size() == 0) begin
        err_count++;
        if (err_count <= 10)
          $display("%0t: result item with none expected: %b", $time, got);
      end else begin
        want = attach_results_due.pop_front();
        if (got.connect_pulse !== want.connect_pulse ||
            got.disconnect_pulse !== want.disconnect_pulse ||
            got.reconnect_note !== want.reconnect_note ||
            got.idle_descriptor_wanted !== want.idle_descriptor_wanted ||
            got.idle_identity_active !== want.idle_identity_active ||
            got.gamepad_ready !== want.gamepad_ready ||
            got.attach_phase !== want.attach_phase) begin
          err_count++;
          if (err_count <= 10)
            $display("%0t: c/d/n/id/ia/gp/ph exp %b/%b/%b/%b/%b/%b/%0d got %b/%b/%b/%b/%b/%b/%0d",
                     $time,
                     want.connect_pulse, want.disconnect_pulse, want.reconnect_note,
                     want.idle_descriptor_wanted, want.idle_identity_active,
                     want.gamepad_ready, want.attach_phase,
                     got.connect_pulse, got.disconnect_pulse, got.reconnect_note,
                     got.idle_descriptor_wanted, got.idle_identity_active,
                     got.gamepad_ready, got.attach_phase);
        end
      end
    end
  end

  // Stimulus
  initial begin
    logic              wake;
    logic              idle;
    logic [DelayW-1:0] dly;

    evt_if.valid <= 1'b0;
    evt_if.action <= '0;
    evt_if.time_now <= '0;
    evt_if.bus_suspended <= 1'b0;
    evt_if.keyboard_busy <= 1'b0;
    evt_if.link_connected <= 1'b0;
    evt_if.served_was_idle <= 1'b0;
    cfg_if.valid <= 1'b0;
    cfg_if.index <= '0;
    cfg_if.data <= '0;

    cfg_wake = 1'b0;
    cfg_idle = 1'b0;
    cfg_delay = REENUM_RESET;
    wanted_now = ID_DETACHED;
    phase_now = PH_DETACHED;
    idle_desc = 1'b0;
    served_idle_q = 1'b0;
    reconnect_due = 1'b0;
    detach_us = '0;
    clock_us = {$urandom, $urandom};

    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part, starting from reset settings (wake off, delay 250000)
    dir_steps = '{
      chk_row(ACT_POLL, 64'd0, F_NONE, QUIET),
      chk_row(ACT_UNUSED, '1, F_ALL, QUIET),
      chk_row(ACT_START, 64'd5, F_NONE, QUIET),          // wake off: stays detached
      cfg_row(CFG_WAKE_EN, 24'd1),
      evt_row(ACT_START, 64'd1000, F_NONE),
      evt_row(ACT_POLL, 64'd250999, F_NONE),             // one short of the delay
      evt_row(ACT_POLL, 64'd251000, F_NONE),             // delay met: connect
      evt_row(ACT_WANT_IDLE, 64'd0, F_NONE),
      evt_row(ACT_POLL, 64'd251001, F_SUSP),             // suspended: ignored
      evt_row(ACT_POLL, 64'd251002, F_KBD),              // keyboard busy: ignored
      evt_row(ACT_POLL, 64'd300000, F_NONE),             // wrong descriptor: detach
      evt_row(ACT_POLL, 64'd299999, F_NONE),             // earlier stamp wraps: connect
      evt_row(ACT_DESC_SERVED, 64'd0, F_WIDLE),
      evt_row(ACT_POLL, 64'd300001, F_NONE),             // idle served as wanted
      evt_row(ACT_WANT_FULL, 64'd0, F_NONE),
      evt_row(ACT_POLL, 64'd400000, F_NONE),             // served but wrong identity
      evt_row(ACT_WANT_DET, 64'd0, F_NONE),
      evt_row(ACT_POLL, 64'd400001, F_NONE),             // go detached
      evt_row(ACT_DESC_SERVED, 64'd0, F_NONE),           // served even when detached
      cfg_row(CFG_IDLE_EN, 24'd1),
      evt_row(ACT_RECONNECT, 64'd0, F_NONE),             // no link: idle identity
      evt_row(ACT_START, 64'd500000, F_NONE),            // pending reconnect survives
      evt_row(ACT_POLL, 64'd500000, F_NONE),
      cfg_row(CFG_REENUM, 24'd0),
      evt_row(ACT_POLL, 64'd500000, F_NONE),             // zero delay: connect at once
      cfg_row(CFG_REENUM, 24'hFFFFFF),
      evt_row(ACT_RECONNECT, 64'd0, F_LINK),
      evt_row(ACT_POLL, '1, F_NONE),
      evt_row(ACT_POLL, '1, F_NONE),                     // no time elapsed
      cfg_row(CFG_WAKE_EN, 24'd0),
      evt_row(ACT_RECONNECT, 64'd0, F_LINK),             // wake off: detached
      evt_row(ACT_POLL, 64'd7, F_NONE)
    };
    foreach (dir_steps[i]) begin
      if (dir_steps[i].is_cfg) begin
        write_reg(dir_steps[i].idx, dir_steps[i].data);
      end else begin
        send_evt(dir_steps[i].ev, dir_steps[i].typed, dir_steps[i].res);
        pace_sender();
      end
    end

    // Random part, one register setting per phase
    for (int k = 0; k < RandPhases; k++) begin
      case (k)
        0: dly = '0;
        1: dly = 24'hFFFFFF;
        2: dly = REENUM_RESET;
        default: dly = ($urandom_range(0, 1) != 0) ? 24'($urandom_range(1, 600))
                                                   : 24'($urandom);
      endcase
      wake = (k == 3) ? 1'b0 : ($urandom_range(0, 5) != 0);
      idle = k[0] ^ ($urandom_range(0, 3) == 0);
      write_reg(CFG_WAKE_EN, 24'(wake));
      write_reg(CFG_IDLE_EN, 24'(idle));
      write_reg(CFG_REENUM, dly);
      if (k == 4) clock_us = 64'hFFFF_FFFF_FFF0_0000;  // run across the wrap
      for (int n = 0; n < ItemsPerPhase; n++) begin
        // hold off until everything has come back
        if (n == ItemsPerPhase / 2 && k[0]) drain_results();
        send_evt(random_event(), 1'b0, QUIET);
        pace_sender();
      end
    end

    drain_results();
    repeat (8) @(posedge clk);
    if (err_count == 0 && attach_results_due.size() == 0)
      $display("PASS usb_attach_identity_sequencer");
    else
      $display("FAIL usb_attach_identity_sequencer");
    $finish;
  end

  // Watchdog
  initial begin
    #5_000_000;
    $display("FAIL usb_attach_identity_sequencer");
    $finish;
  end

endmodule
